FILE: hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types, codes and helpers for the JSON string unescaper
// Holds the decode modes, result kinds, error codes, and the small
// combinational helpers for hex digits, short escapes and UTF-8 encoding.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_ESC      = 3'd1,
        MODE_HEX      = 3'd2,
        MODE_HELD     = 3'd3,
        MODE_HELD_ESC = 3'd4,
        MODE_PAIR_HEX = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_QUOTE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_UNTERM_STRING = 3'd0,
        ERR_UNTERM_ESCAPE = 3'd1,
        ERR_TRUNC_HEX     = 3'd2,
        ERR_BAD_HEX       = 3'd3,
        ERR_UNKNOWN_ESC   = 3'd4,
        ERR_CONTROL_CHAR  = 3'd5
    } err_t;

    localparam int MAX_RESULTS = 6;
    localparam int HELD_BYTES  = 3;
    localparam int MAIN_SLOTS  = 4;

    localparam logic [7:0]  CHR_QUOTE     = 8'h22;
    localparam logic [7:0]  CHR_BACKSLASH = 8'h5C;
    localparam logic [7:0]  CHR_U         = 8'h75;
    localparam logic [7:0]  CTRL_LIMIT    = 8'h20;
    localparam logic [15:0] HIGH_SUR_LO   = 16'hD800;
    localparam logic [15:0] HIGH_SUR_HI   = 16'hDBFF;
    localparam logic [15:0] LOW_SUR_LO    = 16'hDC00;
    localparam logic [15:0] LOW_SUR_HI    = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        err_t       err;
    } res_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] data;
    } esc_t;

    typedef struct packed {
        logic [2:0]            len;
        logic [3:0][7:0]       bytes;
    } enc_t;

    function automatic hex_t hex_val(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // Short escapes other than \u.
    function automatic esc_t esc_map(input logic [7:0] c);
        esc_t e;
        e.ok = 1'b1;
        case (c)
            8'h22:   e.data = 8'h22;
            8'h5C:   e.data = 8'h5C;
            8'h2F:   e.data = 8'h2F;
            8'h62:   e.data = 8'h08;
            8'h66:   e.data = 8'h0C;
            8'h6E:   e.data = 8'h0A;
            8'h72:   e.data = 8'h0D;
            8'h74:   e.data = 8'h09;
            default: begin
                e.ok   = 1'b0;
                e.data = 8'h00;
            end
        endcase
        return e;
    endfunction

    function automatic enc_t utf8_enc(input logic [20:0] cp);
        enc_t e;
        e.bytes = '0;
        if (cp < 21'h80) begin
            e.len      = 3'd1;
            e.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            e.len      = 3'd2;
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            e.len      = 3'd3;
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            e.len      = 3'd4;
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

endpackage

FILE: hdl/json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top: JSON string body decoder to UTF-8
// Decodes raw string body bytes (after the opening quote), including short
// and \u escapes with surrogate pairing, and reports closing quote or error.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                         | tuser         | tlast
//  ---------+-----+-------------------------------+---------------+-------------
//  s_       | in  | in_byte                       | text_ended    | -
//  m_       | out | out_byte, error_code          | out_kind      | last_of_run
//
//  One input beat is decoded in the cycle it is accepted; its 0 to 6 results
//  are loaded into a result buffer and leave one per cycle from there.
//  A beat with at most one result sustains one beat per cycle while m_tready is high;
//  a beat with more results holds the input while the buffer drains.
//  Reset (aresetn low, synchronous) empties the buffer and clears the decoder.
//  m_tready low holds the current result and, while the buffer is not empty,
//  the input.
//
module json_string_unescape_utf8_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] text_ended
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] error_code, [15:11] zero
    output logic [1:0]  m_tuser,   // [1:0] out_kind
    output logic        m_tlast    // last_of_run
);

    jsu_pkg::mode_t      mode_reg, mode_next;
    logic [15:0]         acc_reg, acc_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic                bad_reg, bad_next;
    logic [9:0]          held_reg, held_next;

    jsu_pkg::res_t       buf_reg  [jsu_pkg::MAX_RESULTS];
    jsu_pkg::res_t       buf_next [jsu_pkg::MAX_RESULTS];
    logic [2:0]          count_reg, count_next;
    logic [2:0]          idx_reg;

    logic                in_accept;
    logic [7:0]          c;
    logic                ended;

    logic                pre_held;
    logic [2:0]          main_cnt;
    jsu_pkg::res_t [jsu_pkg::MAIN_SLOTS-1:0] main_list;
    logic                fin;
    jsu_pkg::kind_t      fin_kind;
    jsu_pkg::err_t       fin_err;

    jsu_pkg::hex_t       hv;
    jsu_pkg::esc_t       em;
    logic [15:0]         acc_shift;
    logic                bad_any;
    jsu_pkg::enc_t       enc_held;
    jsu_pkg::enc_t       enc_lone;
    jsu_pkg::enc_t       enc_pair;
    logic                is_pair;
    logic                is_low;
    logic                is_high;

    assign c         = s_tdata;
    assign ended     = s_tuser;
    assign m_tvalid  = (idx_reg != count_reg);
    assign m_tlast   = (idx_reg == count_reg - 3'd1);
    assign s_tready  = !m_tvalid || (m_tready && m_tlast);
    assign in_accept = s_tvalid && s_tready;

    assign m_tuser   = buf_reg[idx_reg].kind;
    assign m_tdata   = {5'd0, buf_reg[idx_reg].err, buf_reg[idx_reg].data};

    assign hv        = jsu_pkg::hex_val(c);
    assign em        = jsu_pkg::esc_map(c);
    assign acc_shift = hv.ok ? {acc_reg[11:0], hv.val} : acc_reg;
    assign bad_any   = bad_reg || !hv.ok;
    assign enc_held  = jsu_pkg::utf8_enc({5'd0, 6'b110110, held_reg});
    assign enc_lone  = jsu_pkg::utf8_enc({5'd0, acc_shift});
    assign enc_pair  = jsu_pkg::utf8_enc(jsu_pkg::SUPP_BASE + {1'b0, held_reg, acc_shift[9:0]});
    assign is_pair   = (mode_reg == jsu_pkg::MODE_PAIR_HEX);
    assign is_low    = (acc_shift >= jsu_pkg::LOW_SUR_LO) && (acc_shift <= jsu_pkg::LOW_SUR_HI);
    assign is_high   = (acc_shift >= jsu_pkg::HIGH_SUR_LO) && (acc_shift <= jsu_pkg::HIGH_SUR_HI);

    // Next decoder state for one beat.
    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        bad_next  = bad_reg;
        held_next = held_reg;

        if (fin) begin
            // Quote or error: back to a fresh string body.
            mode_next = jsu_pkg::MODE_NORMAL;
            acc_next  = '0;
            cnt_next  = '0;
            bad_next  = 1'b0;
            held_next = '0;
        end else begin
            case (mode_reg)
                jsu_pkg::MODE_ESC,
                jsu_pkg::MODE_HELD_ESC: begin
                    if (mode_reg == jsu_pkg::MODE_HELD_ESC && c == jsu_pkg::CHR_U) begin
                        mode_next = jsu_pkg::MODE_PAIR_HEX;
                        acc_next  = '0;
                        cnt_next  = '0;
                        bad_next  = 1'b0;
                    end else begin
                        if (mode_reg == jsu_pkg::MODE_HELD_ESC) begin
                            held_next = '0;
                        end
                        if (em.ok) begin
                            mode_next = jsu_pkg::MODE_NORMAL;
                        end else if (c == jsu_pkg::CHR_U) begin
                            mode_next = jsu_pkg::MODE_HEX;
                            acc_next  = '0;
                            cnt_next  = '0;
                            bad_next  = 1'b0;
                        end
                    end
                end
                jsu_pkg::MODE_HEX,
                jsu_pkg::MODE_PAIR_HEX: begin
                    acc_next = acc_shift;
                    if (cnt_reg != 2'd3) begin
                        cnt_next = cnt_reg + 2'd1;
                        bad_next = bad_any;
                    end else begin
                        mode_next = jsu_pkg::MODE_NORMAL;
                        acc_next  = '0;
                        cnt_next  = '0;
                        bad_next  = 1'b0;
                        held_next = '0;
                        if (!(is_pair && is_low) && is_high) begin
                            // Hold the high surrogate so that a following low-surrogate escape can pair with it.
                            held_next = acc_shift[9:0];
                            mode_next = jsu_pkg::MODE_HELD;
                        end
                    end
                end
                default: begin
                    if (mode_reg == jsu_pkg::MODE_HELD && c == jsu_pkg::CHR_BACKSLASH) begin
                        mode_next = jsu_pkg::MODE_HELD_ESC;
                    end else begin
                        if (mode_reg == jsu_pkg::MODE_HELD) begin
                            held_next = '0;
                        end
                        mode_next = (c == jsu_pkg::CHR_BACKSLASH) ? jsu_pkg::MODE_ESC
                                                                  : jsu_pkg::MODE_NORMAL;
                    end
                end
            endcase
        end
    end

    // Results of one beat: the held-surrogate prefix and the main results.
    always_comb begin
        pre_held  = 1'b0;
        main_cnt  = 3'd0;
        main_list = '0;
        fin       = 1'b0;
        fin_kind  = jsu_pkg::KIND_ERROR;
        fin_err   = jsu_pkg::ERR_UNTERM_STRING;

        if (ended) begin
            fin = 1'b1;
            case (mode_reg)
                jsu_pkg::MODE_ESC:      fin_err = jsu_pkg::ERR_UNTERM_ESCAPE;
                jsu_pkg::MODE_HEX,
                jsu_pkg::MODE_PAIR_HEX: fin_err = jsu_pkg::ERR_TRUNC_HEX;
                jsu_pkg::MODE_HELD: begin
                    pre_held = 1'b1;
                    fin_err  = jsu_pkg::ERR_UNTERM_STRING;
                end
                jsu_pkg::MODE_HELD_ESC: begin
                    pre_held = 1'b1;
                    fin_err  = jsu_pkg::ERR_UNTERM_ESCAPE;
                end
                default:                fin_err = jsu_pkg::ERR_UNTERM_STRING;
            endcase
        end else begin
            case (mode_reg)
                jsu_pkg::MODE_ESC,
                jsu_pkg::MODE_HELD_ESC: begin
                    if (!(mode_reg == jsu_pkg::MODE_HELD_ESC && c == jsu_pkg::CHR_U)) begin
                        if (mode_reg == jsu_pkg::MODE_HELD_ESC) begin
                            pre_held = 1'b1;
                        end
                        if (em.ok) begin
                            main_list[0] = '{jsu_pkg::KIND_BYTE, em.data,
                                             jsu_pkg::ERR_UNTERM_STRING};
                            main_cnt     = 3'd1;
                        end else if (c != jsu_pkg::CHR_U) begin
                            fin     = 1'b1;
                            fin_err = jsu_pkg::ERR_UNKNOWN_ESC;
                        end
                    end
                end
                jsu_pkg::MODE_HEX,
                jsu_pkg::MODE_PAIR_HEX: begin
                    if (cnt_reg == 2'd3) begin
                        if (bad_any) begin
                            fin     = 1'b1;
                            fin_err = jsu_pkg::ERR_BAD_HEX;
                        end else if (is_pair && is_low) begin
                            for (int j = 0; j < jsu_pkg::MAIN_SLOTS; j++) begin
                                main_list[j] = '{jsu_pkg::KIND_BYTE, enc_pair.bytes[j],
                                                 jsu_pkg::ERR_UNTERM_STRING};
                            end
                            main_cnt = enc_pair.len;
                        end else begin
                            pre_held = is_pair;
                            if (!is_high) begin
                                for (int j = 0; j < jsu_pkg::MAIN_SLOTS; j++) begin
                                    main_list[j] = '{jsu_pkg::KIND_BYTE, enc_lone.bytes[j],
                                                     jsu_pkg::ERR_UNTERM_STRING};
                                end
                                main_cnt = enc_lone.len;
                            end
                        end
                    end
                end
                default: begin
                    if (!(mode_reg == jsu_pkg::MODE_HELD && c == jsu_pkg::CHR_BACKSLASH)) begin
                        if (mode_reg == jsu_pkg::MODE_HELD) begin
                            pre_held = 1'b1;
                        end
                        if (c == jsu_pkg::CHR_QUOTE) begin
                            fin      = 1'b1;
                            fin_kind = jsu_pkg::KIND_QUOTE;
                        end else if (c == jsu_pkg::CHR_BACKSLASH) begin
                            main_cnt = 3'd0;
                        end else if (c < jsu_pkg::CTRL_LIMIT) begin
                            fin     = 1'b1;
                            fin_err = jsu_pkg::ERR_CONTROL_CHAR;
                        end else begin
                            main_list[0] = '{jsu_pkg::KIND_BYTE, c,
                                             jsu_pkg::ERR_UNTERM_STRING};
                            main_cnt     = 3'd1;
                        end
                    end
                end
            endcase
        end

        // Quote or error: a single main result, after any held-surrogate prefix.
        if (fin) begin
            main_list    = '0;
            main_list[0] = '{fin_kind, 8'h00,
                             (fin_kind == jsu_pkg::KIND_ERROR) ? fin_err
                                                               : jsu_pkg::ERR_UNTERM_STRING};
            main_cnt     = 3'd1;
        end
    end

    // Place the held-surrogate bytes ahead of the main results.
    always_comb begin
        for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
            buf_next[i] = '0;
            if (pre_held) begin
                if (i < jsu_pkg::HELD_BYTES) begin
                    buf_next[i] = '{jsu_pkg::KIND_BYTE, enc_held.bytes[i],
                                    jsu_pkg::ERR_UNTERM_STRING};
                end else begin
                    buf_next[i] = main_list[i - jsu_pkg::HELD_BYTES];
                end
            end else if (i < jsu_pkg::MAIN_SLOTS) begin
                buf_next[i] = main_list[i];
            end
        end
        count_next = main_cnt + (pre_held ? 3'(jsu_pkg::HELD_BYTES) : 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= jsu_pkg::MODE_NORMAL;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            bad_reg   <= 1'b0;
            held_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end else if (in_accept) begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            bad_reg   <= bad_next;
            held_reg  <= held_next;
            count_reg <= count_next;
            idx_reg   <= '0;
        end else if (m_tvalid && m_tready) begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // Result payload: load the whole run on an accepted beat.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
                buf_reg[i] <= buf_next[i];
            end
        end
    end

endmodule
